FILE: hdl/mrte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrte_pkg
// Shared widths, field codes and controller/datapath interface types for the
// mask rule trigger engine.
// ----------------------------------------------------------------------------
package mrte_pkg;

  localparam int InputBits    = 8;
  localparam int OutputBits   = 8;
  localparam int FlagBits     = 16;
  localparam int DelayBits    = 16;
  localparam int WordBits     = 16;
  localparam int WordsPerRule = 13;
  localparam int CfgBits      = 5;
  localparam int RuleIdxBits  = 4;
  localparam int FieldSelBits = 4;

  // rule field codes
  localparam logic [FieldSelBits-1:0] FS_IN_OFF     = 4'd0;
  localparam logic [FieldSelBits-1:0] FS_IN_ON      = 4'd1;
  localparam logic [FieldSelBits-1:0] FS_OUT_OFF    = 4'd2;
  localparam logic [FieldSelBits-1:0] FS_OUT_ON     = 4'd3;
  localparam logic [FieldSelBits-1:0] FS_FLAG_OFF   = 4'd4;
  localparam logic [FieldSelBits-1:0] FS_FLAG_ON    = 4'd5;
  localparam logic [FieldSelBits-1:0] FS_OUT_SET    = 4'd6;
  localparam logic [FieldSelBits-1:0] FS_OUT_CLR    = 4'd7;
  localparam logic [FieldSelBits-1:0] FS_OUT_TGL    = 4'd8;
  localparam logic [FieldSelBits-1:0] FS_FLAG_SET   = 4'd9;
  localparam logic [FieldSelBits-1:0] FS_FLAG_CLR   = 4'd10;
  localparam logic [FieldSelBits-1:0] FS_FLAG_TGL   = 4'd11;
  localparam logic [FieldSelBits-1:0] FS_PRELOAD    = 4'd12;

  // operation and result kind codes
  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_SCAN      = 1'b1;
  localparam logic KIND_FIRED   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef logic [WordBits-1:0] word_t;
  typedef word_t [WordsPerRule-1:0] rule_row_t;

  typedef struct packed {
    logic write_field;
    logic scan_start;
    logic fetch;
    logic eval;
    logic push_notice;
    logic push_summary;
  } dp_cmd_t;

  typedef struct packed {
    logic fire;
    logic slot_free;
  } dp_status_t;

endpackage

FILE: hdl/mrte_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrte_datapath
// Rule table, per-rule delay counters, output/flag registers, the rule
// evaluator and the result register.
// ----------------------------------------------------------------------------
module mrte_datapath import mrte_pkg::*; #(
  parameter int NUM_RULES = 16,
  parameter int IDX_W     = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  input  logic [IDX_W-1:0]        cur_idx_i,
  input  logic [IDX_W-1:0]        rd_addr_i,
  input  logic [RuleIdxBits-1:0]  rule_index_i,
  input  logic [FieldSelBits-1:0] field_select_i,
  input  logic [WordBits-1:0]     field_value_i,
  input  logic [InputBits-1:0]    pin_inputs_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    out_kind_o,
  output logic [RuleIdxBits-1:0]  out_rule_o,
  output logic [OutputBits-1:0]   out_levels_o,
  output logic [FlagBits-1:0]     out_flags_o,
  output logic                    out_last_o
);

  localparam int CntBits = DelayBits + 1;

  rule_row_t                rule_mem [NUM_RULES];
  rule_row_t                rd_q;
  logic [InputBits-1:0]     pins_q;
  logic [OutputBits-1:0]    out_q;
  logic [FlagBits-1:0]      flag_q;
  logic [CntBits-1:0]       dc_q [NUM_RULES];
  logic [NUM_RULES-1:0]     met_q;

  logic                     out_valid_q;
  logic                     out_kind_q;
  logic [RuleIdxBits-1:0]   out_rule_q;
  logic [OutputBits-1:0]    out_levels_q;
  logic [FlagBits-1:0]      out_flags_q;
  logic                     out_last_q;

  logic                     wr_ok;
  logic [IDX_W-1:0]         wr_addr;
  logic [InputBits-1:0]     m_in_off, m_in_on;
  logic [OutputBits-1:0]    m_out_off, m_out_on, a_out_set, a_out_clr, a_out_tgl;
  logic [FlagBits-1:0]      m_flag_off, m_flag_on, a_flag_set, a_flag_clr, a_flag_tgl;
  logic [CntBits-1:0]       preload;
  logic [CntBits-1:0]       cnt;
  logic [CntBits-1:0]       cnt_d;
  logic                     cond_ok;
  logic                     fire;
  logic [OutputBits-1:0]    out_act;
  logic [FlagBits-1:0]      flag_act;
  logic                     slot_free;
  logic                     push;

  assign wr_ok   = (32'(rule_index_i) < NUM_RULES) && (field_select_i <= FS_PRELOAD);
  assign wr_addr = IDX_W'(rule_index_i);

  // rule table: one word written per load, whole row read per rule
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_field && wr_ok) begin
      rule_mem[wr_addr][field_select_i] <= field_value_i;
    end
    if (cmd_i.fetch) begin
      rd_q <= rule_mem[rd_addr_i];
    end
    if (cmd_i.scan_start) begin
      pins_q <= pin_inputs_i;
    end
  end

  assign m_in_off   = rd_q[FS_IN_OFF][InputBits-1:0];
  assign m_in_on    = rd_q[FS_IN_ON][InputBits-1:0];
  assign m_out_off  = rd_q[FS_OUT_OFF][OutputBits-1:0];
  assign m_out_on   = rd_q[FS_OUT_ON][OutputBits-1:0];
  assign m_flag_off = rd_q[FS_FLAG_OFF][FlagBits-1:0];
  assign m_flag_on  = rd_q[FS_FLAG_ON][FlagBits-1:0];
  assign a_out_set  = rd_q[FS_OUT_SET][OutputBits-1:0];
  assign a_out_clr  = rd_q[FS_OUT_CLR][OutputBits-1:0];
  assign a_out_tgl  = rd_q[FS_OUT_TGL][OutputBits-1:0];
  assign a_flag_set = rd_q[FS_FLAG_SET][FlagBits-1:0];
  assign a_flag_clr = rd_q[FS_FLAG_CLR][FlagBits-1:0];
  assign a_flag_tgl = rd_q[FS_FLAG_TGL][FlagBits-1:0];
  assign preload    = {1'b0, rd_q[FS_PRELOAD][DelayBits-1:0]};

  always_comb begin
    cond_ok = ((m_in_off & pins_q) == '0) && ((m_in_on & pins_q) == m_in_on) &&
              ((m_out_off & out_q) == '0) && ((m_out_on & out_q) == m_out_on) &&
              ((m_flag_off & flag_q) == '0) && ((m_flag_on & flag_q) == m_flag_on);
    cnt  = dc_q[cur_idx_i];
    fire = cond_ok && (cnt == preload);
    // while the condition is met: at the preload the counter steps past it, below it counts, above it holds
    if (cond_ok) begin
      cnt_d = (cnt <= preload) ? cnt + CntBits'(1) : cnt;
    end else begin
      cnt_d = met_q[cur_idx_i] ? cnt : '0;
    end
    out_act  = ((out_q | a_out_set) & ~a_out_clr) ^ a_out_tgl;
    flag_act = ((flag_q | a_flag_set) & ~a_flag_clr) ^ a_flag_tgl;
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign push      = cmd_i.push_notice || cmd_i.push_summary;

  assign status_o.fire      = fire;
  assign status_o.slot_free = slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q       <= '0;
      flag_q      <= '0;
      met_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_RULES; i++) begin
        dc_q[i] <= '0;
      end
    end else begin
      if (cmd_i.eval) begin
        dc_q[cur_idx_i]  <= cnt_d;
        met_q[cur_idx_i] <= cond_ok;
        if (fire) begin
          out_q  <= out_act;
          flag_q <= flag_act;
        end
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_notice) begin
      out_kind_q   <= KIND_FIRED;
      out_rule_q   <= RuleIdxBits'(cur_idx_i);
      out_levels_q <= out_act;
      out_flags_q  <= flag_act;
      out_last_q   <= 1'b0;
    end else if (cmd_i.push_summary) begin
      out_kind_q   <= KIND_SUMMARY;
      out_rule_q   <= '0;
      out_levels_q <= out_q;
      out_flags_q  <= flag_q;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_rule_o   = out_rule_q;
  assign out_levels_o = out_levels_q;
  assign out_flags_o  = out_flags_q;
  assign out_last_o   = out_last_q;

endmodule

FILE: hdl/mrte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrte_ctrl
// Scan sequencer: takes input transactions, walks the active rules one per
// cycle unless a notice stalls, and closes each scan with a summary.
// ----------------------------------------------------------------------------
module mrte_ctrl import mrte_pkg::*; #(
  parameter int NUM_RULES = 16,
  parameter int IDX_W     = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgBits-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_op_i,
  output dp_cmd_t            cmd_o,
  input  dp_status_t         status_i,
  output logic [IDX_W-1:0]   cur_idx_o,
  output logic [IDX_W-1:0]   rd_addr_o
);

  localparam int CNT_W = $clog2(NUM_RULES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_SUMM = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CfgBits-1:0] active_q;
  logic [CNT_W-1:0]   n_sat;
  logic               last_rule;

  assign cfg_ready_o = 1'b1;
  assign n_sat = (32'(active_q) > NUM_RULES) ? CNT_W'(NUM_RULES) : CNT_W'(active_q);
  assign last_rule = (CNT_W'(idx_q) + CNT_W'(1)) == n_q;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    idx_d      = idx_q;
    n_d        = n_q;
    rd_addr_o  = idx_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr_o  = '0;
        if (in_valid_i) begin
          if (in_op_i == OP_SCAN) begin
            cmd_o.scan_start = 1'b1;
            cmd_o.fetch      = 1'b1;
            idx_d            = '0;
            n_d              = n_sat;
            state_d          = (n_sat == '0) ? ST_SUMM : ST_EVAL;
          end else begin
            cmd_o.write_field = 1'b1;
          end
        end
      end
      ST_EVAL: begin
        // a firing rule waits for the result register to free up
        if (!status_i.fire || status_i.slot_free) begin
          cmd_o.eval        = 1'b1;
          cmd_o.push_notice = status_i.fire;
          if (last_rule) begin
            state_d = ST_SUMM;
          end else begin
            idx_d       = IDX_W'(idx_q + 1'b1);
            rd_addr_o   = idx_d;
            cmd_o.fetch = 1'b1;
          end
        end
      end
      ST_SUMM: begin
        if (status_i.slot_free) begin
          cmd_o.push_summary = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      n_q      <= '0;
      active_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      if (cfg_valid_i) begin
        active_q <= cfg_data_i;
      end
    end
  end

  assign cur_idx_o = idx_q;

endmodule

FILE: hdl/mask_rule_trigger_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_rule_trigger_engine
// Table of trigger rules with mask conditions, delayed firing and
// output/flag actions, evaluated in order on each scan.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   tuser: op; tdata: rule_index, field_select, field_value, pins
// m_axis    out  tuser: kind; tlast: last; tdata: fired_rule, outputs, flags
// cfg       in   data: active_rules
//
// a load transaction writes one rule field; a scan fetches rule 0 as it is
// taken, then walks min(active_rules, NUM_RULES) rules, one per cycle when not
// stalled, through the single rule evaluator, and ends by queuing the summary
// a notice or the summary that finds the result register full stalls the
// scan until it frees up; no input is taken while a scan is in progress
// reset clears counters, outputs and flags at once; the rule table is not
// cleared and must be loaded before rules are scanned
// ----------------------------------------------------------------------------
module mask_rule_trigger_engine import mrte_pkg::*; #(
  parameter int NUM_RULES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgBits-1:0] cfg_data_i,     // active_rules
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i, // rule_index, field_select, field_value, pin_inputs
  input  logic               s_axis_tuser_i, // op
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [31:0]        m_axis_tdata_o, // fired_rule, output_levels, flag_word, zero pad
  output logic               m_axis_tuser_o, // kind
  output logic               m_axis_tlast_o
);

  localparam int IDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

  dp_cmd_t               cmd;
  dp_status_t            status;
  logic [IDX_W-1:0]      cur_idx;
  logic [IDX_W-1:0]      rd_addr;
  logic [RuleIdxBits-1:0] out_rule;
  logic [OutputBits-1:0] out_levels;
  logic [FlagBits-1:0]   out_flags;

  mrte_ctrl #(
    .NUM_RULES (NUM_RULES),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .cmd_o       (cmd),
    .status_i    (status),
    .cur_idx_o   (cur_idx),
    .rd_addr_o   (rd_addr)
  );

  mrte_datapath #(
    .NUM_RULES (NUM_RULES),
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cur_idx_i      (cur_idx),
    .rd_addr_i      (rd_addr),
    .rule_index_i   (s_axis_tdata_i[3:0]),
    .field_select_i (s_axis_tdata_i[7:4]),
    .field_value_i  (s_axis_tdata_i[23:8]),
    .pin_inputs_i   (s_axis_tdata_i[31:24]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_kind_o     (m_axis_tuser_o),
    .out_rule_o     (out_rule),
    .out_levels_o   (out_levels),
    .out_flags_o    (out_flags),
    .out_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, out_flags, out_levels, out_rule};

endmodule

FILE: hdl/mrte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrte_checker
// Port-level checks on result ordering and scan handshaking.
// ----------------------------------------------------------------------------
module mrte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // only the summary closes a scan
  a_last_is_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == m_axis_tuser_o))
    else $error("tlast does not match summary kind");

  a_summary_rule_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[3:0] == 4'd0))
    else $error("summary carries a rule index");

  // a scan transaction blocks the input until its summary is queued
  a_scan_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i) |=> !s_axis_tready_o)
    else $error("input taken during a scan");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind mask_rule_trigger_engine mrte_checker u_mrte_checker (.*);
